[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the rectangle raster engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[rtl/rre_pkg.sv]
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types and constants of the rectangle raster engine.
// ----------------------------------------------------------------------------
package rre_pkg;

  // default sizing
  localparam int DefMaxSide  = 512;
  localparam int DefFracBits = 8;

  // field widths
  localparam int RectW = 20;
  localparam int CfgW  = 10;
  localparam int ByteW = 8;
  localparam int PixW  = 9;

  // configuration register indexes
  localparam logic [1:0] RegCanvasWidth  = 2'd0;
  localparam logic [1:0] RegCanvasHeight = 2'd1;
  localparam logic [1:0] RegBackground   = 2'd2;

  // register reset values
  localparam logic [CfgW-1:0]  ResetSide = 10'd256;
  localparam logic [ByteW-1:0] ResetBg   = 8'd32;

  // action codes
  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActDraw  = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  // status codes
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatReject = 2'd1;
  localparam logic [1:0] StatRange  = 2'd2;

  // rectangle kinds
  localparam logic [ByteW-1:0] KindFilled  = 8'h52;
  localparam logic [ByteW-1:0] KindOutline = 8'h72;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StRead,
    StFetch
  } rre_state_e;

  // controller to datapath
  typedef struct packed {
    logic       begin_sweep;
    logic       sweep_clear;
    logic       sweep_en;
    logic       load_read;
    logic       rd_en;
    logic       finish;
    logic [1:0] fin_status;
    logic       take_pixel;
  } rre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw_ok;
    logic read_in_range;
    logic last_pixel;
  } rre_stat_t;

endpackage

[rtl/rre_ram.sv]
// ----------------------------------------------------------------------------
// rre_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rre_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rre_ctrl.sv]
// ----------------------------------------------------------------------------
// rre_ctrl
// Sequencer of the raster engine: dispatches items, runs the pixel sweep
// and the read fetch, and orders the result strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rre_ctrl
  import rre_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] action_i,
  input  rre_stat_t  stat_i,
  output rre_cmd_t   cmd_o,
  output logic       busy_o
);

  rre_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          unique case (action_i)
            ActClear: state_d = StSweep;
            ActDraw:  state_d = stat_i.draw_ok ? StSweep : StIdle;
            ActRead:  state_d = stat_i.read_in_range ? StRead : StIdle;
            default:  state_d = StIdle;
          endcase
        end
      end
      StSweep: begin
        if (stat_i.last_pixel) begin
          state_d = StIdle;
        end
      end
      StRead:  state_d = StFetch;
      StFetch: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.fin_status = StatOk;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          unique case (action_i)
            ActClear: begin
              cmd_o.begin_sweep = 1'b1;
              cmd_o.sweep_clear = 1'b1;
            end
            ActDraw: begin
              if (stat_i.draw_ok) begin
                cmd_o.begin_sweep = 1'b1;
              end else begin
                cmd_o.finish     = 1'b1;
                cmd_o.fin_status = StatReject;
              end
            end
            ActRead: begin
              if (stat_i.read_in_range) begin
                cmd_o.load_read = 1'b1;
              end else begin
                cmd_o.finish     = 1'b1;
                cmd_o.fin_status = StatRange;
              end
            end
            default: cmd_o.finish = 1'b1;
          endcase
        end
      end
      StSweep: begin
        cmd_o.sweep_en = 1'b1;
        cmd_o.finish   = stat_i.last_pixel;
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
      end
      StFetch: begin
        cmd_o.finish     = 1'b1;
        cmd_o.take_pixel = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  // the sweep ends on the last pixel and a fetch always follows a read
  `ASSERT_ON(a_sweep_ends, (state_q == StSweep) && stat_i.last_pixel |=> state_q == StIdle, "sweep did not end on last pixel")
  `ASSERT_ON(a_read_fetch, state_q == StRead |=> state_q == StFetch, "read not followed by fetch")

endmodule

[rtl/rre_datapath.sv]
// ----------------------------------------------------------------------------
// rre_datapath
// Configuration registers, rectangle bounds, pixel sweep counters,
// edge/interior classification, canvas memory and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rre_datapath
  import rre_pkg::*;
#(
  parameter int MaxSide  = DefMaxSide,
  parameter int FracBits = DefFracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  // item fields
  input  logic [ByteW-1:0]        kind_byte_i,
  input  logic signed [RectW-1:0] rect_left_i,
  input  logic signed [RectW-1:0] rect_top_i,
  input  logic signed [RectW-1:0] rect_width_i,
  input  logic signed [RectW-1:0] rect_height_i,
  input  logic [ByteW-1:0]        paint_byte_i,
  input  logic [PixW-1:0]         pixel_col_i,
  input  logic [PixW-1:0]         pixel_row_i,
  // control
  input  rre_cmd_t                cmd_i,
  output rre_stat_t               stat_o,
  // result
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [ByteW-1:0]        pixel_value_o
);

  localparam int CW     = (MaxSide > 1) ? $clog2(MaxSide) : 1;
  localparam int SW     = $clog2(MaxSide + 1);
  localparam int CoordW = (CW + FracBits + 2 > RectW + 2) ? CW + FracBits + 2 : RectW + 2;
  localparam int Depth  = 1 << (2 * CW);
  localparam logic signed [CoordW-1:0] UnitOne = CoordW'(1) << FracBits;

  function automatic logic [SW-1:0] clamp_side(logic [CfgW-1:0] v);
    logic [SW-1:0] s;
    if (v == '0) begin
      s = SW'(1);
    end else if (32'(v) > MaxSide) begin
      s = SW'(MaxSide);
    end else begin
      s = SW'(v);
    end
    return s;
  endfunction

  localparam logic [SW-1:0] ResetWidth = clamp_side(ResetSide);

  logic [SW-1:0]    width_q, height_q;
  logic [ByteW-1:0] bg_q;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetWidth;
      bg_q     <= ResetBg;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCanvasWidth:  width_q  <= clamp_side(cfg_data_i);
        RegCanvasHeight: height_q <= clamp_side(cfg_data_i);
        RegBackground:   bg_q     <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // item checks
  logic kind_ok, size_ok;
  assign kind_ok = (kind_byte_i == KindFilled) || (kind_byte_i == KindOutline);
  assign size_ok = !rect_width_i[RectW-1] && (rect_width_i != '0) &&
                   !rect_height_i[RectW-1] && (rect_height_i != '0);
  assign stat_o.draw_ok       = kind_ok && size_ok;
  assign stat_o.read_in_range = (32'(pixel_col_i) < 32'(width_q)) &&
                                (32'(pixel_row_i) < 32'(height_q));

  // rectangle bounds from the item
  logic signed [CoordW-1:0] left_ext, top_ext, right_ext, bottom_ext;
  assign left_ext   = CoordW'(rect_left_i);
  assign top_ext    = CoordW'(rect_top_i);
  assign right_ext  = left_ext + CoordW'(rect_width_i);
  assign bottom_ext = top_ext + CoordW'(rect_height_i);

  logic signed [CoordW-1:0] x_lo_q, x_hi_q, x_in_lo_q, x_in_hi_q;
  logic signed [CoordW-1:0] y_lo_q, y_hi_q, y_in_lo_q, y_in_hi_q;
  logic                     filled_q, clear_mode_q;
  logic [ByteW-1:0]         paint_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_sweep) begin
      x_lo_q    <= left_ext;
      x_hi_q    <= right_ext;
      x_in_lo_q <= left_ext + UnitOne;
      x_in_hi_q <= right_ext - UnitOne;
      y_lo_q    <= top_ext;
      y_hi_q    <= bottom_ext;
      y_in_lo_q <= top_ext + UnitOne;
      y_in_hi_q <= bottom_ext - UnitOne;
      filled_q  <= (kind_byte_i == KindFilled);
      paint_q   <= paint_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_mode_q <= 1'b0;
    end else if (cmd_i.begin_sweep) begin
      clear_mode_q <= cmd_i.sweep_clear;
    end
  end

  // pixel counters, also hold the read address
  logic [CW-1:0] col_q, row_q;
  logic          col_last, row_last;

  assign col_last = (SW'(col_q) + SW'(1)) == width_q;
  assign row_last = (SW'(row_q) + SW'(1)) == height_q;
  assign stat_o.last_pixel = col_last && row_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.begin_sweep) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load_read) begin
      col_q <= CW'(pixel_col_i);
      row_q <= CW'(pixel_row_i);
    end else if (cmd_i.sweep_en) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + CW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // classify the current pixel against the rectangle
  logic signed [CoordW-1:0] px, py;
  logic                     covered, inner, paint_hit;

  assign px = signed'(CoordW'(col_q) << FracBits);
  assign py = signed'(CoordW'(row_q) << FracBits);

  assign covered = (px >= x_lo_q) && (px <= x_hi_q) &&
                   (py >= y_lo_q) && (py <= y_hi_q);
  assign inner   = (px >= x_in_lo_q) && (px <= x_in_hi_q) &&
                   (py >= y_in_lo_q) && (py <= y_in_hi_q);
  assign paint_hit = covered && (filled_q || !inner);

  // canvas memory
  logic                    ram_we;
  logic [ByteW-1:0]        ram_wdata, ram_rdata;
  logic [$clog2(Depth)-1:0] ram_addr;

  assign ram_we    = cmd_i.sweep_en && (clear_mode_q || paint_hit);
  assign ram_wdata = clear_mode_q ? bg_q : paint_q;
  assign ram_addr  = {row_q, col_q};

  rre_ram #(
    .Width (ByteW),
    .Depth (Depth)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.rd_en),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // result registers
  logic             done_q;
  logic [1:0]       status_q;
  logic [ByteW-1:0] pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      status_q <= StatOk;
      pixel_q  <= '0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) begin
        status_q <= cmd_i.fin_status;
        pixel_q  <= cmd_i.take_pixel ? ram_rdata : '0;
      end
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign pixel_value_o = pixel_q;

  // the sweep never leaves the active canvas
  `ASSERT_NEVER(a_sweep_in_canvas, cmd_i.sweep_en && ((SW'(col_q) >= width_q) || (SW'(row_q) >= height_q)), "sweep outside active canvas")

endmodule

[rtl/rectangle_raster_engine_core.sv]
// ----------------------------------------------------------------------------
// rectangle_raster_engine_core
// Axis-aligned rectangle rasterizer on a byte canvas held in one RAM.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. Every item gives
// exactly one result, shown for one cycle with done_o high; the receiver
// cannot stall it, so sample status_o and pixel_value_o whenever done_o is
// high. A clear or an accepted draw sweeps the active canvas one pixel per
// cycle through the single RAM port, then gives its result. A read in
// range loads the address, reads the RAM into its output register and
// then registers the result. A rejected draw, a read outside the canvas
// or the unused action answers in the next cycle. The canvas RAM is not
// cleared after reset: issue a clear before the first read.
// Configuration writes are always ready and take effect at once; change
// them only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rectangle_raster_engine_core
  import rre_pkg::*;
#(
  parameter int MaxSide  = DefMaxSide,
  parameter int FracBits = DefFracBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  // item command
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              action_i,
  input  logic [ByteW-1:0]        kind_byte_i,
  input  logic signed [RectW-1:0] rect_left_i,
  input  logic signed [RectW-1:0] rect_top_i,
  input  logic signed [RectW-1:0] rect_width_i,
  input  logic signed [RectW-1:0] rect_height_i,
  input  logic [ByteW-1:0]        paint_byte_i,
  input  logic [PixW-1:0]         pixel_col_i,
  input  logic [PixW-1:0]         pixel_row_i,
  // result
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [ByteW-1:0]        pixel_value_o
);

  rre_cmd_t  cmd;
  rre_stat_t stat;

  // sequencer
  rre_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath with canvas memory
  rre_datapath #(
    .MaxSide  (MaxSide),
    .FracBits (FracBits)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_byte_i   (kind_byte_i),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .paint_byte_i  (paint_byte_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .pixel_value_o (pixel_value_o)
  );

  // a result only follows work in progress or an item taken the cycle before
  `ASSERT_ON(a_done_cause, done_o |-> $past(busy_o) || $past(start_i), "result without an item")

endmodule
